@@ src/pfwr_pkg.sv @@
// Package for the prefix-framed word receiver.
// Holds shared constants, register indexes and the state and result types.
// No dependencies.
package pfwr_pkg;

   // Default sizes of the framing.
   localparam int PAYLOAD_BITS_DEF = 12;
   localparam int WORD_BITS_DEF    = 16;

   // Fixed field widths.
   localparam int FIELD_BITS  = 16;
   localparam int PREFIX_BITS = 4;
   localparam int COUNT_BITS  = 4;
   localparam int DIST_BITS   = 8;
   localparam int CSR_IDX_BITS = 8;
   localparam int CSR_DATA_BITS = 8;

   // Reset values of the configuration registers.
   localparam logic [PREFIX_BITS-1:0] PREFIX_RESET = 4'b1110;
   localparam logic [DIST_BITS-1:0]   WAIT_RESET   = 8'd8;

   // Saturation limit of the distance counter.
   localparam logic [DIST_BITS-1:0]   DIST_MAX     = 8'd255;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_PREFIX_PATTERN = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAIT_BITS      = 8'd1;

   // Framing and handshake state, apart from the bit window.
   typedef struct packed {
      logic                    prefix_armed;
      logic [COUNT_BITS-1:0]   payload_count;
      logic [2*FIELD_BITS-1:0] found_history;
      logic                    capture_pending;
      logic [DIST_BITS-1:0]    bits_since_event;
      logic                    expect_low;
      logic                    flag_level;
   } ctl_state_type;

   // One result transaction.
   typedef struct packed {
      logic                  found_valid;
      logic [FIELD_BITS-1:0] found_word;
      logic                  event_seen;
      logic [FIELD_BITS-1:0] event_latest_word;
      logic [FIELD_BITS-1:0] event_previous_word;
      logic                  after_valid;
      logic [FIELD_BITS-1:0] after_word;
      logic [DIST_BITS-1:0]  after_distance;
      logic                  target_match;
      logic                  out_level;
   } rsp_type;

endpackage

@@ src/pfwr_step.sv @@
// Per-bit step logic of the prefix-framed word receiver.
// Computes the next state and the result for one received bit.
// Depends on pfwr_pkg.
module pfwr_step #(
   parameter int PAYLOAD_BITS = pfwr_pkg::PAYLOAD_BITS_DEF,
   parameter int WORD_BITS    = pfwr_pkg::WORD_BITS_DEF
) (
   input  logic [WORD_BITS-1:0]             window,
   input  pfwr_pkg::ctl_state_type          state,
   input  logic [pfwr_pkg::PREFIX_BITS-1:0] prefix_pattern,
   input  logic [pfwr_pkg::DIST_BITS-1:0]   wait_bits,
   input  logic                             rx_bit,
   input  logic                             pin_level,
   input  logic [pfwr_pkg::FIELD_BITS-1:0]  target_word,
   output logic [WORD_BITS-1:0]             window_next,
   output pfwr_pkg::ctl_state_type          state_next,
   output pfwr_pkg::rsp_type                result
);
   import pfwr_pkg::*;

   localparam logic [COUNT_BITS-1:0] PAYLOAD_LAST = COUNT_BITS'(PAYLOAD_BITS);

   logic [FIELD_BITS-1:0]   word_view;
   logic [DIST_BITS-1:0]    dist_inc;
   logic [COUNT_BITS-1:0]   count_inc;
   logic                    prefix_hit;
   logic                    found;
   logic                    after;
   logic                    hs_event;
   logic [2*FIELD_BITS-1:0] history_next;

   // Shift the new bit into the window.
   assign window_next = {window[WORD_BITS-2:0], rx_bit};

   // Low 16 bits of the window, zero-extended when the window is narrower.
   if (WORD_BITS >= FIELD_BITS) begin : g_wide
      assign word_view = window_next[FIELD_BITS-1:0];
   end else begin : g_narrow
      assign word_view = {{(FIELD_BITS-WORD_BITS){1'b0}}, window_next};
   end

   // Saturating distance count and payload count.
   assign dist_inc  = (state.bits_since_event != DIST_MAX) ?
                      state.bits_since_event + 1'b1 : state.bits_since_event;
   assign count_inc = state.payload_count + 1'b1;

   // Framing, capture and handshake decisions.
   assign prefix_hit   = (window_next[PREFIX_BITS-1:0] == prefix_pattern);
   assign found        = !prefix_hit && state.prefix_armed && (count_inc == PAYLOAD_LAST);
   assign after        = found && state.capture_pending && (dist_inc <= wait_bits);
   assign history_next = found ? {state.found_history[FIELD_BITS-1:0], word_view}
                               : state.found_history;
   assign hs_event     = state.expect_low ? !pin_level : pin_level;

   // Next state and result.
   always_comb begin
      state_next = state;
      result     = '0;

      if (prefix_hit) begin
         state_next.prefix_armed  = 1'b1;
         state_next.payload_count = '0;
      end else if (state.prefix_armed) begin
         state_next.payload_count = count_inc;
         if (found) begin
            state_next.prefix_armed = 1'b0;
         end
      end

      state_next.found_history    = history_next;
      state_next.bits_since_event = dist_inc;
      if (after) begin
         state_next.capture_pending = 1'b0;
      end

      result.found_valid = found;
      result.found_word  = found ? word_view : '0;
      result.after_valid = after;
      result.after_word  = after ? word_view : '0;
      result.after_distance = after ? dist_inc : '0;

      if (hs_event) begin
         state_next.capture_pending  = 1'b1;
         state_next.bits_since_event = '0;
         state_next.expect_low       = !state.expect_low;
         result.event_seen          = 1'b1;
         result.event_latest_word   = history_next[FIELD_BITS-1:0];
         result.event_previous_word = history_next[2*FIELD_BITS-1:FIELD_BITS];
      end else if (word_view == target_word) begin
         state_next.flag_level = !state.flag_level;
         result.target_match   = 1'b1;
      end

      result.out_level = state_next.flag_level;
   end

endmodule

@@ src/prefix_framed_word_receiver_top.sv @@
// The prefix-framed serial word receiver: top level with the channel registers.
// Instantiates pfwr_step; depends on pfwr_pkg.
//
// The receiver takes one serial bit per transaction and returns one result
// transaction per bit. It sustains one bit per clock when the result channel
// does not stall: a bit is held in the input register, and as it moves on the
// step logic updates the framing state and writes the result register.
// The state update of the step logic closes its loop through the state
// registers alone, which sets this rate. Back-pressure on the result channel
// stalls the input register, and the input channel stays ready as long as the
// input register can move on. Configuration writes are taken at any cycle and
// are expected only while no bit is in flight.
module prefix_framed_word_receiver_top #(
   parameter int PAYLOAD_BITS = pfwr_pkg::PAYLOAD_BITS_DEF,
   parameter int WORD_BITS    = pfwr_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfwr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pfwr_pkg::CSR_DATA_BITS-1:0] csr_data,
   // Input channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_rx_bit,
   input  logic                               req_pin_level,
   input  logic [pfwr_pkg::FIELD_BITS-1:0]    req_target_word,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found_valid,
   output logic [pfwr_pkg::FIELD_BITS-1:0]    rsp_found_word,
   output logic                               rsp_event_seen,
   output logic [pfwr_pkg::FIELD_BITS-1:0]    rsp_event_latest_word,
   output logic [pfwr_pkg::FIELD_BITS-1:0]    rsp_event_previous_word,
   output logic                               rsp_after_valid,
   output logic [pfwr_pkg::FIELD_BITS-1:0]    rsp_after_word,
   output logic [pfwr_pkg::DIST_BITS-1:0]     rsp_after_distance,
   output logic                               rsp_target_match,
   output logic                               rsp_out_level
);
   import pfwr_pkg::*;

   logic [PREFIX_BITS-1:0] prefix_ff;
   logic [DIST_BITS-1:0]   wait_ff;

   logic                   in_valid_ff;
   logic                   in_rx_ff;
   logic                   in_pin_ff;
   logic [FIELD_BITS-1:0]  in_target_ff;

   logic [WORD_BITS-1:0]   window_ff;
   logic [WORD_BITS-1:0]   window_in;
   ctl_state_type          state_ff;
   ctl_state_type          state_in;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic                   advance;

   // Configuration registers, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PREFIX_RESET;
         wait_ff   <= WAIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PREFIX_PATTERN: prefix_ff <= csr_data[PREFIX_BITS-1:0];
            CSR_WAIT_BITS:      wait_ff   <= csr_data[DIST_BITS-1:0];
            default:            ;
         endcase
      end
   end

   // The held bit moves into the result register when that register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_rx_ff     <= req_rx_bit;
         in_pin_ff    <= req_pin_level;
         in_target_ff <= req_target_word;
      end
   end

   // Step logic for one bit.
   pfwr_step #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .WORD_BITS    (WORD_BITS)
   ) u_step (
      .window         (window_ff),
      .state          (state_ff),
      .prefix_pattern (prefix_ff),
      .wait_bits      (wait_ff),
      .rx_bit         (in_rx_ff),
      .pin_level      (in_pin_ff),
      .target_word    (in_target_ff),
      .window_next    (window_in),
      .state_next     (state_in),
      .result         (rsp_in)
   );

   // Receiver state, updated once per bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         state_ff  <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         state_ff  <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_found_valid         = rsp_ff.found_valid;
   assign rsp_found_word          = rsp_ff.found_word;
   assign rsp_event_seen          = rsp_ff.event_seen;
   assign rsp_event_latest_word   = rsp_ff.event_latest_word;
   assign rsp_event_previous_word = rsp_ff.event_previous_word;
   assign rsp_after_valid         = rsp_ff.after_valid;
   assign rsp_after_word          = rsp_ff.after_word;
   assign rsp_after_distance      = rsp_ff.after_distance;
   assign rsp_target_match        = rsp_ff.target_match;
   assign rsp_out_level           = rsp_ff.out_level;

   // A capture only happens on a bit that completes a word.
   a_after_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.after_valid |-> rsp_ff.found_valid)
      else $error("capture reported without a found word");

   // A target match is suppressed on a handshake event.
   a_match_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.target_match && rsp_ff.event_seen))
      else $error("target match reported together with an event");

   // A captured word lies within the configured window.
   a_after_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.after_valid |-> rsp_ff.after_distance <= wait_ff)
      else $error("capture distance beyond the wait window");

   // The output flag changes only on a target match.
   a_flag_toggle: assert property (@(posedge clock) disable iff (reset)
      advance |-> (state_in.flag_level != state_ff.flag_level) == rsp_in.target_match)
      else $error("output flag changed without a target match");

   // An empty input register always takes a new transaction.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalled with an empty input register");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the prefix-framed serial word receiver.
// Depends on pfwr_pkg and prefix_framed_word_receiver_top.
module testbench;
   import pfwr_pkg::*;

   // Register indexes the block does not decode; writes to them are dropped.
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_UNUSED = CSR_WAIT_BITS + 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAST_INDEX   = '1;
   // Cycles without any transaction before the run is declared hung.
   localparam int HANG_LIMIT = 1000;
   // Mismatch lines printed before further ones are only counted.
   localparam int PRINT_LIMIT = 40;

   // Keeps its own copy of the framing state, predicts one result per bit and
   // checks the results in order.
   class deframer_scoreboard;
      logic [PREFIX_BITS-1:0]  prefix;
      logic [DIST_BITS-1:0]    wait_lim;
      logic [FIELD_BITS-1:0]   window;
      logic                    armed;
      logic [COUNT_BITS-1:0]   count;
      logic [2*FIELD_BITS-1:0] history;
      logic                    capture;
      logic [DIST_BITS-1:0]    since;
      logic                    expect_low;
      logic                    flag;
      rsp_type                 predicted_rsp[$];
      int                      errors;
      int                      checked;

      function new();
         errors = 0;
         checked = 0;
         prefix = PREFIX_RESET;
         wait_lim = WAIT_RESET;
         window = '0;
         armed = 1'b0;
         count = '0;
         history = '0;
         capture = 1'b0;
         since = '0;
         expect_low = 1'b0;
         flag = 1'b0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_PREFIX_PATTERN: prefix = data[PREFIX_BITS-1:0];
            CSR_WAIT_BITS:      wait_lim = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return predicted_rsp.size();
      endfunction

      // Works out the result of one accepted bit and queues it.
      function void note_bit(logic rx, logic pin, logic [FIELD_BITS-1:0] target);
         rsp_type want;
         want = '0;
         window = {window[FIELD_BITS-2:0], rx};
         if (since != DIST_MAX) since = since + 1'b1;

         // Prefix search restarts the payload count on every hit.
         if (window[PREFIX_BITS-1:0] == prefix) begin
            armed = 1'b1;
            count = '0;
         end else if (armed) begin
            count = count + 1'b1;
            if (count == COUNT_BITS'(PAYLOAD_BITS_DEF)) begin
               armed = 1'b0;
               want.found_valid = 1'b1;
               want.found_word = window;
            end
         end

         // A found word enters the history and may close a pending capture.
         if (want.found_valid) begin
            history = {history[FIELD_BITS-1:0], want.found_word};
            if (capture && since <= wait_lim) begin
               want.after_valid = 1'b1;
               want.after_word = want.found_word;
               want.after_distance = since;
               capture = 1'b0;
            end
         end

         // The handshake pin must alternate, high first.
         if (expect_low ? !pin : pin) begin
            want.event_seen = 1'b1;
            want.event_latest_word = history[FIELD_BITS-1:0];
            want.event_previous_word = history[2*FIELD_BITS-1:FIELD_BITS];
            capture = 1'b1;
            since = '0;
            expect_low = !expect_low;
         end else if (window == target) begin
            want.target_match = 1'b1;
            flag = !flag;
         end
         want.out_level = flag;
         predicted_rsp.push_back(want);
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_LIMIT) $display("mismatch at result %0d: %s", checked, what);
      endtask

      task check_field(string name, logic [FIELD_BITS-1:0] got, logic [FIELD_BITS-1:0] want);
         if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
      endtask

      // Compares one accepted result with the oldest prediction.
      task check_result(rsp_type got);
         rsp_type want;
         if (predicted_rsp.size() == 0) begin
            report("result transaction with no prediction waiting");
         end else begin
            want = predicted_rsp.pop_front();
            check_field("found_valid", got.found_valid, want.found_valid);
            check_field("found_word", got.found_word, want.found_word);
            check_field("event_seen", got.event_seen, want.event_seen);
            check_field("event_latest_word", got.event_latest_word, want.event_latest_word);
            check_field("event_previous_word", got.event_previous_word,
                        want.event_previous_word);
            check_field("after_valid", got.after_valid, want.after_valid);
            check_field("after_word", got.after_word, want.after_word);
            check_field("after_distance", got.after_distance, want.after_distance);
            check_field("target_match", got.target_match, want.target_match);
            check_field("out_level", got.out_level, want.out_level);
         end
         checked++;
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_rx_bit = 1'b0;
   logic                     req_pin_level = 1'b0;
   logic [FIELD_BITS-1:0]    req_target_word = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic                     rsp_found_valid;
   logic [FIELD_BITS-1:0]    rsp_found_word;
   logic                     rsp_event_seen;
   logic [FIELD_BITS-1:0]    rsp_event_latest_word;
   logic [FIELD_BITS-1:0]    rsp_event_previous_word;
   logic                     rsp_after_valid;
   logic [FIELD_BITS-1:0]    rsp_after_word;
   logic [DIST_BITS-1:0]     rsp_after_distance;
   logic                     rsp_target_match;
   logic                     rsp_out_level;
   rsp_type                  rsp_seen;

   deframer_scoreboard       sb;
   bit                       quiet = 1'b0;
   bit                       gaps_on = 1'b0;
   bit                       stall_gate = 1'b1;
   int                       stall_left = 0;
   int                       idle_cycles = 0;
   int                       bits_sent = 0;
   int                       toggle_span = 20;
   logic                     pin_now = 1'b0;
   logic [PREFIX_BITS-1:0]   prefix_now = PREFIX_RESET;

   prefix_framed_word_receiver_top i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_rx_bit              (req_rx_bit),
      .req_pin_level           (req_pin_level),
      .req_target_word         (req_target_word),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_found_valid         (rsp_found_valid),
      .rsp_found_word          (rsp_found_word),
      .rsp_event_seen          (rsp_event_seen),
      .rsp_event_latest_word   (rsp_event_latest_word),
      .rsp_event_previous_word (rsp_event_previous_word),
      .rsp_after_valid         (rsp_after_valid),
      .rsp_after_word          (rsp_after_word),
      .rsp_after_distance      (rsp_after_distance),
      .rsp_target_match        (rsp_target_match),
      .rsp_out_level           (rsp_out_level)
   );

   assign rsp_seen = {rsp_found_valid, rsp_found_word, rsp_event_seen, rsp_event_latest_word,
                      rsp_event_previous_word, rsp_after_valid, rsp_after_word,
                      rsp_after_distance, rsp_target_match, rsp_out_level};

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: checks each result transaction, stalls in short bursts and
   // watches for a hang.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
         rsp_ready <= 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_seen);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;

         if ($urandom_range(0, 59) == 0) stall_gate = !stall_gate;
         if (quiet) begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_gate && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end

         if (idle_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Presents one bit and returns at the edge where it was accepted; valid
   // stays high so that a following bit can go out back to back.
   task automatic send_bit(input logic rx, input logic pin, input logic [FIELD_BITS-1:0] target);
      req_valid <= 1'b1;
      req_rx_bit <= rx;
      req_pin_level <= pin;
      req_target_word <= target;
      do @(posedge clock); while (!req_ready);
      sb.note_bit(rx, pin, target);
      bits_sent++;
   endtask

   // Random sender gap with valid held low.
   task automatic sender_gap();
      if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Waits until every predicted result has come back, then writes a register.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, data);
   endtask

   // Handshake pin: held level that toggles now and then, with rare glitches.
   function automatic logic next_pin();
      if ($urandom_range(0, 24) == 0) return 1'($urandom_range(0, 1));
      if ($urandom_range(0, toggle_span - 1) == 0) pin_now = ~pin_now;
      return pin_now;
   endfunction

   // One well-formed message: prefix plus random payload; half the time the
   // node is waiting for exactly this word.
   task automatic send_frame();
      logic [FIELD_BITS-1:0] word;
      logic [FIELD_BITS-1:0] target;
      word = {prefix_now, 12'($urandom_range(0, 4095))};
      target = ($urandom_range(0, 1) == 1) ? word : FIELD_BITS'($urandom_range(0, 65535));
      gaps_on = ($urandom_range(0, 1) == 1);
      for (int i = FIELD_BITS - 1; i >= 0; i--) begin
         sender_gap();
         send_bit(word[i], next_pin(), target);
      end
   endtask

   // A few random bits between messages.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) begin
         sender_gap();
         send_bit(1'($urandom_range(0, 1)), next_pin(), FIELD_BITS'($urandom_range(0, 65535)));
      end
   endtask

   // One phase of random traffic under a fresh register setting.
   task automatic run_phase(input logic [PREFIX_BITS-1:0] prefix, input logic [DIST_BITS-1:0] lim,
                            input int span, input int budget, input bit long_gap);
      int goal;
      write_reg(CSR_PREFIX_PATTERN, {4'($urandom_range(0, 15)), prefix});
      write_reg(CSR_WAIT_BITS, lim);
      prefix_now = prefix;
      toggle_span = span;
      goal = bits_sent + budget;
      // A long silent stretch after an event drives the distance into saturation.
      if (long_gap) begin
         pin_now = ~pin_now;
         repeat (270) send_bit(1'b0, pin_now, FIELD_BITS'($urandom_range(0, 65535)));
         send_frame();
      end
      while (bits_sent < goal) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_frame();
      end
   endtask

   initial begin
      logic [FIELD_BITS-1:0] word;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: a message with an event inside it, so the word is captured,
      // followed by an event that reports it; targets at both extremes.
      word = {PREFIX_RESET, 12'hFFF};
      for (int i = FIELD_BITS - 1; i >= 0; i--)
         send_bit(word[i], (i <= 6), word);
      send_bit(1'b0, 1'b0, 16'h0000);
      send_bit(1'b1, 1'b0, 16'hFFFF);
      send_bit(1'b1, 1'b1, 16'hFFFF);
      send_bit(1'b0, 1'b1, 16'h0000);
      pin_now = 1'b1;

      // Random phases, including the register extremes and a prefix of zero.
      run_phase(4'd1, 8'd0, 12, 300, 1'b0);
      run_phase(4'd15, 8'd255, 400, 300, 1'b1);
      write_reg(CSR_FIRST_UNUSED + CSR_IDX_BITS'($urandom_range(0, 252)),
                CSR_DATA_BITS'($urandom_range(0, 255)));
      write_reg(CSR_LAST_INDEX, CSR_DATA_BITS'($urandom_range(0, 255)));
      run_phase(4'd0, 8'd20, 30, 300, 1'b0);
      run_phase(4'($urandom_range(1, 15)), 8'($urandom_range(0, 255)), 20, 300, 1'b0);
      run_phase(PREFIX_RESET, WAIT_RESET, 15, 300, 1'b0);
      quiet = 1'b1;
      run_phase(4'($urandom_range(1, 15)), 8'($urandom_range(1, 40)), 40, 300, 1'b0);

      // Drain and let the pipeline settle.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
